// ===== hw/rtl/mexp_pkg.sv =====
package mexp_pkg;

    localparam int DATA_BITS      = 32;
    localparam int WORD_BITS_DEF  = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOAD_ACC,
        ST_MUL_ACC,
        ST_LOAD_SQ,
        ST_MUL_SQ,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, start base reduction
        logic step;      // one multiplier / reducer step
        logic sel_one;   // addend is 1 (base reduction) instead of the square
        logic load_acc;  // start acc * sq
        logic load_sq;   // start sq * sq
        logic wr_acc;
        logic wr_sq;
        logic shift_ex;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_last;
        logic ex_zero;
        logic ex_b0;
        logic ex_b1;
        logic ex_rest_zero;
    } status_t;

endpackage

// ===== hw/rtl/mexp_ctrl.sv =====
module mexp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  mexp_pkg::status_t   status,
    output mexp_pkg::cmd_t      cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != mexp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (status.cnt_last)
                begin
                    if (status.ex_zero)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else if (status.ex_b0)
                    begin
                        state_next = mexp_pkg::ST_LOAD_ACC;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_LOAD_SQ;
                    end
                end
            end
            mexp_pkg::ST_LOAD_ACC:
            begin
                state_next = mexp_pkg::ST_MUL_ACC;
            end
            mexp_pkg::ST_MUL_ACC:
            begin
                if (status.cnt_last)
                begin
                    // no square needed once the remaining exponent bits are clear
                    if (status.ex_rest_zero)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_LOAD_SQ;
                    end
                end
            end
            mexp_pkg::ST_LOAD_SQ:
            begin
                state_next = mexp_pkg::ST_MUL_SQ;
            end
            mexp_pkg::ST_MUL_SQ:
            begin
                if (status.cnt_last)
                begin
                    if (status.ex_b1)
                    begin
                        state_next = mexp_pkg::ST_LOAD_ACC;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_LOAD_SQ;
                    end
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            mexp_pkg::ST_REDUCE:
            begin
                cmd.step    = 1'b1;
                cmd.sel_one = 1'b1;
                cmd.wr_sq   = status.cnt_last;
            end
            mexp_pkg::ST_LOAD_ACC:
            begin
                cmd.load_acc = 1'b1;
            end
            mexp_pkg::ST_MUL_ACC:
            begin
                cmd.step   = 1'b1;
                cmd.wr_acc = status.cnt_last;
            end
            mexp_pkg::ST_LOAD_SQ:
            begin
                cmd.load_sq = 1'b1;
            end
            mexp_pkg::ST_MUL_SQ:
            begin
                cmd.step     = 1'b1;
                cmd.wr_sq    = status.cnt_last;
                cmd.shift_ex = status.cnt_last;
            end
            mexp_pkg::ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mexp_dp.sv =====
module mexp_dp #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [mexp_pkg::DATA_BITS-1:0]  modulus,
    input  logic [mexp_pkg::DATA_BITS-1:0]  base,
    input  logic [mexp_pkg::DATA_BITS-1:0]  exponent,
    input  mexp_pkg::cmd_t                  cmd,
    output mexp_pkg::status_t               status,
    output logic [mexp_pkg::DATA_BITS-1:0]  power_residue
);

    localparam int CW = $clog2(WORD_BITS);
    localparam int SW = WORD_BITS + 2;

    logic [WORD_BITS-1:0]           mod_reg;
    logic [WORD_BITS-1:0]           acc_reg;
    logic [WORD_BITS-1:0]           sq_reg;
    logic [WORD_BITS-1:0]           ex_reg;
    logic [WORD_BITS-1:0]           prod_reg;
    logic [WORD_BITS-1:0]           mpl_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [mexp_pkg::DATA_BITS-1:0] res_reg;

    logic [WORD_BITS-1:0]           addend;
    logic [SW-1:0]                  sum;
    logic [SW-1:0]                  m1;
    logic [SW-1:0]                  m2;
    logic [WORD_BITS-1:0]           prod_next;
    logic                           mod_zero;
    logic                           mod_one;

    assign mod_zero = (mod_reg == '0);
    assign mod_one  = (mod_reg == WORD_BITS'(1));

    // one interleaved step: r = (2r + bit * addend) mod m, with r, addend < m
    assign addend = cmd.sel_one ? WORD_BITS'(1) : sq_reg;
    assign sum    = {1'b0, prod_reg, 1'b0} + (mpl_reg[WORD_BITS-1] ? {2'b00, addend} : '0);
    assign m1     = {2'b00, mod_reg};
    assign m2     = {1'b0, mod_reg, 1'b0};

    always_comb
    begin
        if (mod_zero)
        begin
            prod_next = sum[WORD_BITS-1:0];   // wraps mod 2^WORD_BITS
        end
        else if (sum >= m2)
        begin
            prod_next = WORD_BITS'(sum - m2);
        end
        else if (sum >= m1)
        begin
            prod_next = WORD_BITS'(sum - m1);
        end
        else
        begin
            prod_next = sum[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WORD_BITS'(1);
        end
        else if (cfg_write)
        begin
            mod_reg <= modulus[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mpl_reg  <= base[WORD_BITS-1:0];
            ex_reg   <= exponent[WORD_BITS-1:0];
            acc_reg  <= mod_one ? '0 : WORD_BITS'(1);
            prod_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.load_acc || cmd.load_sq)
        begin
            mpl_reg  <= cmd.load_acc ? acc_reg : sq_reg;
            prod_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            mpl_reg  <= {mpl_reg[WORD_BITS-2:0], 1'b0};
            prod_reg <= prod_next;
            cnt_reg  <= cnt_reg + CW'(1);
        end

        if (cmd.wr_acc)
        begin
            acc_reg <= prod_next;
        end
        if (cmd.wr_sq)
        begin
            sq_reg <= prod_next;
        end
        if (cmd.shift_ex)
        begin
            ex_reg <= {1'b0, ex_reg[WORD_BITS-1:1]};
        end

        // ex_reg only reaches zero here when the exponent was zero
        if (cmd.out_load)
        begin
            res_reg <= (ex_reg == '0) ? mexp_pkg::DATA_BITS'(1)
                                      : mexp_pkg::DATA_BITS'(acc_reg);
        end
    end

    assign status.cnt_last     = (cnt_reg == CW'(WORD_BITS - 1));
    assign status.ex_zero      = (ex_reg == '0);
    assign status.ex_b0        = ex_reg[0];
    assign status.ex_b1        = ex_reg[1];
    assign status.ex_rest_zero = (ex_reg[WORD_BITS-1:1] == '0);

    assign power_residue = res_reg;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Modular exponentiation: power_residue = base ^ exponent mod modulus,
// right-to-left square-and-multiply over the low WORD_BITS bits of each operand.
// Config: write modulus on the cfg channel (cfg_valid with cfg_ready, which is
// always high); write only while no item is in flight. Modulus resets to 1,
// and a modulus of 0 wraps products mod 2^WORD_BITS.
// Input: base and exponent are taken when in_valid is high and in_stall low.
// One item is worked at a time; in_stall stays high from acceptance until
// the result has moved into the output register.
// Schedule: W = WORD_BITS, e the exponent's bit length. The base is reduced
// first; each modular product is then a load step and a run of steps on the
// shared bit-serial multiplier: one multiply per set exponent bit and one
// squaring per bit below the top one, so p <= 2e - 1 products. A zero
// exponent skips the products and goes straight to the output.
// Output: power_residue is held in a register with out_valid; a stalled result
// stays unchanged, and the next item may be accepted while it waits.
// Reset clears the controller and the output valid and sets the modulus back to 1; an item in flight is dropped.
module modular_exponentiation #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mexp_pkg::DATA_BITS-1:0]  modulus,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mexp_pkg::DATA_BITS-1:0]  base,
    input  logic [mexp_pkg::DATA_BITS-1:0]  exponent,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mexp_pkg::DATA_BITS-1:0]  power_residue
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .modulus       (modulus),
        .base          (base),
        .exponent      (exponent),
        .cmd           (cmd),
        .status        (status),
        .power_residue (power_residue)
    );

endmodule

// ===== verif/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    localparam int W          = mexp_pkg::DATA_BITS;
    localparam int QUIET_MAX  = 20000;
    localparam int DRAIN_WAIT = 2200;
    localparam int HOLD_LEN   = 3000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [W-1:0] cfg_modulus = '0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [W-1:0] in_base = '0;
    logic [W-1:0] in_exponent = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] power_residue;

    logic [W-1:0] pending_residues[$];
    logic [W-1:0] cur_modulus = 1;
    int           send_idle_pct = 0;
    int           out_stall_pct = 0;
    int           hold_req = 0;
    logic         rx_holdoff = 1'b0;
    int           errors = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           modulus_writes = 0;

    modular_exponentiation u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .modulus       (cfg_modulus),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .base          (in_base),
        .exponent      (in_exponent),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .power_residue (power_residue)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // modulus 0 means plain wraparound at W bits
    function automatic logic [63:0] reduce_mod(logic [63:0] x, logic [W-1:0] m);
        if (m == 0)
            return {32'h0, x[W-1:0]};
        return x % {32'h0, m};
    endfunction

    function automatic logic [W-1:0] power_mod(logic [W-1:0] b, logic [W-1:0] e,
                                               logic [W-1:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [W-1:0] ex;
        int i;
        acc = 64'd1;
        sq = {32'h0, b};
        ex = e;
        for (i = 0; i < W && ex != 0; i++)
        begin
            if (ex[0])
                acc = reduce_mod(acc * sq, m);
            ex = ex >> 1;
            sq = reduce_mod(sq * sq, m);
        end
        return acc[W-1:0];
    endfunction

    task automatic send_item(logic [W-1:0] b, logic [W-1:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_base     <= b;
        in_exponent <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_residues.push_back(power_mod(b, e, cur_modulus));
        items_sent++;
    endtask

    task automatic wait_drained();
        while (pending_residues.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(logic [W-1:0] value);
        wait_drained();
        cfg_valid   <= 1'b1;
        cfg_modulus <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        cur_modulus = value;
        modulus_writes++;
    endtask

    function automatic logic [W-1:0] random_exponent(int max_width);
        int w;
        logic [63:0] mask;
        if ($urandom_range(19) == 0)
            return '0;
        case ($urandom_range(9))
            0:       w = $urandom_range(max_width, (max_width > 24) ? 25 : 1);
            1, 2:    w = $urandom_range((max_width < 24) ? max_width : 24, 1);
            default: w = $urandom_range((max_width < 12) ? max_width : 12, 1);
        endcase
        mask = (64'd1 << w) - 1;
        return ($urandom & mask[W-1:0]) | (32'd1 << (w - 1));
    endfunction

    function automatic logic [W-1:0] random_base();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? '1 : '0;
            1:       return cur_modulus + $urandom_range(2) - 1;
            2, 3:    return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // modulus still at its reset value of 1
    task automatic test_reset_modulus();
        send_idle_pct = 0;
        out_stall_pct = 0;
        send_item(32'd0, 32'd0);
        send_item(32'd5, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd7, 32'd3);
        in_valid <= 1'b0;
    endtask

    // toy RSA key n = 61 * 53, e = 17, d = 2753
    task automatic test_rsa_key();
        logic [W-1:0] cipher;
        write_modulus(32'd3233);
        cipher = power_mod(32'd65, 32'd17, 32'd3233);
        send_item(32'd65, 32'd17);
        send_item(cipher, 32'd2753);
        send_item(32'd0, 32'd1);
        send_item(32'd0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd0);
        send_item(32'hFFFF_FFFF, 32'd1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd1, 32'hFFFF_FFFF);
        send_item(32'd3233, 32'd5);
        send_item(32'd3234, 32'd5);
        in_valid <= 1'b0;
    endtask

    task automatic test_zero_modulus();
        write_modulus(32'd0);
        send_item(32'd3, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd2);
        send_item(32'd2, 32'd32);
        send_item(32'd0, 32'd0);
        in_valid <= 1'b0;
    endtask

    task automatic test_full_modulus();
        write_modulus(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFE, 32'd3);
        send_item(32'hFFFF_FFFF, 32'd5);
        send_item(32'h1234_5678, 32'hFFFF_FFFF);
        in_valid <= 1'b0;
    endtask

    task automatic test_random_traffic(logic [W-1:0] m, int idle_pct, int stall_pct,
                                       int count);
        write_modulus(m);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        repeat (count)
            send_item(random_base(), random_exponent(32));
        in_valid <= 1'b0;
    endtask

    // output held off long enough for the block to back up into its input
    task automatic test_output_holdoff();
        write_modulus($urandom | 32'h8000_0001);
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_req = HOLD_LEN;
        repeat (8)
            send_item(random_base(), random_exponent(6));
        in_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        logic [W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_residues.size() == 0)
            begin
                errors++;
                $error("power_residue: unexpected result %08h", power_residue);
            end
            else
            begin
                want = pending_residues.pop_front();
                if (want !== power_residue)
                begin
                    errors++;
                    $error("power_residue: expected %08h, got %08h", want, power_residue);
                end
            end
        end
        out_stall <= rx_holdoff || ($urandom_range(99) < out_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                rx_holdoff <= 1'b1;
                repeat (hold_req) @(posedge clk);
                rx_holdoff <= 1'b0;
                hold_req = 0;
            end
        end
    end

    // counts cycles in which no channel moves anything
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d idle cycles, %0d results pending",
                 QUIET_MAX, pending_residues.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_rsa_key();
        test_zero_modulus();
        test_full_modulus();
        test_random_traffic($urandom | 32'h8000_0000, 0, 0, 52);
        test_random_traffic(32'hFFFF_FFFF, 80, 0, 52);
        test_random_traffic(32'd0, 0, 80, 52);
        test_random_traffic($urandom_range(1000, 2), 23, 23, 52);
        test_random_traffic($urandom, 0, 0, 52);
        test_output_holdoff();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d items and %0d results over %0d modulus writes", items_sent,
                 results_seen, modulus_writes);
        $display("zero, one and all-ones moduli, full exponents, idle/stall mixes, hold-off");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/mexp_dp.sv
hw/rtl/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
